// ===== sv/round_robin_queue_interleave_core_assert.svh =====
// Assertion macros shared by the rrqi modules.
// Every module that uses them has ports named clock and reset.
`ifndef ROUND_ROBIN_QUEUE_INTERLEAVE_CORE_ASSERT_SVH
`define ROUND_ROBIN_QUEUE_INTERLEAVE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define RRQI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define RRQI_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`else

`define RRQI_ASSERT(lbl, prop, msg)

`define RRQI_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ===== sv/rrqi_pkg.sv =====
package rrqi_pkg;

   localparam int NUM_LISTS  = 8;
   localparam int LIST_DEPTH = 16;

   localparam int VALUE_W = 32;
   localparam int QSEL_W  = 3;
   localparam int STAT_W  = 2;

   localparam int LIST_W  = $clog2(NUM_LISTS);
   localparam int DEPTH_W = $clog2(LIST_DEPTH);
   localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_LISTS * LIST_DEPTH;
   localparam int ADDR_W  = $clog2(MEM_DEPTH);

   // command queue between front and back
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_TAKE = 1'b1;

   localparam logic [STAT_W-1:0] ST_PUSHED  = 2'd0;
   localparam logic [STAT_W-1:0] ST_DROPPED = 2'd1;
   localparam logic [STAT_W-1:0] ST_TAKEN   = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

   typedef struct packed {
      logic                mem_wr;
      logic                mem_rd;
      logic [ADDR_W-1:0]   addr;
      logic [VALUE_W-1:0]  data;
      logic [QSEL_W-1:0]   src;
      logic [STAT_W-1:0]   status;
   } cmd_type;

endpackage

// ===== sv/rrqi_if.sv =====
interface rrqi_req_if import rrqi_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic [QSEL_W-1:0]         queue_select;
   logic signed [VALUE_W-1:0] push_value;

   modport source (output valid, output opcode, output queue_select, output push_value,
                   input ready);
   modport sink   (input valid, input opcode, input queue_select, input push_value,
                   output ready);
endinterface

interface rrqi_rsp_if import rrqi_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] out_value;
   logic [QSEL_W-1:0]         source_queue;
   logic [STAT_W-1:0]         status;

   modport source (output valid, output out_value, output source_queue, output status,
                   input ready);
   modport sink   (input valid, input out_value, input source_queue, input status,
                   output ready);
endinterface

// ===== sv/rrqi_front.sv =====
`include "round_robin_queue_interleave_core_assert.svh"

module rrqi_front import rrqi_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   rrqi_req_if.sink       req_ch,
   input  logic           cmd_full,
   output logic           cmd_push,
   output cmd_type        cmd_out
);

   logic [DEPTH_W-1:0] head_ff  [NUM_LISTS];
   logic [DEPTH_W-1:0] head_in  [NUM_LISTS];
   logic [CNT_W-1:0]   count_ff [NUM_LISTS];
   logic [CNT_W-1:0]   count_in [NUM_LISTS];
   logic [LIST_W-1:0]  next_start_ff;
   logic [LIST_W-1:0]  next_start_in;

   logic               accept;
   logic               is_take;
   logic [NUM_LISTS-1:0] nonempty;
   logic [NUM_LISTS-1:0] upper_mask;
   logic               hi_found;
   logic [LIST_W-1:0]  hi_idx;
   logic               any_found;
   logic [LIST_W-1:0]  lo_idx;
   logic [LIST_W-1:0]  pick;
   logic [LIST_W-1:0]  sel_idx;
   logic               sel_ok;
   logic               push_ok;
   logic               take_ok;
   logic [CNT_W:0]     slot_sum;
   logic [DEPTH_W-1:0] slot;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [DEPTH_W:0]   head_inc;
   logic [LIST_W:0]    pick_inc;

   function automatic logic [LIST_W:0] first_set(input logic [NUM_LISTS-1:0] vec);
      logic [LIST_W:0] res;
      res = '0;
      for (int q = NUM_LISTS - 1; q >= 0; q--) begin
         if (vec[q]) begin
            res = {1'b1, LIST_W'(q)};
         end
      end
      return res;
   endfunction

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !cmd_full;
   assign is_take      = (req_ch.opcode == OP_TAKE);

   // rotating find-first: first non-empty queue at or after next_start, else wrap
   always_comb begin
      for (int q = 0; q < NUM_LISTS; q++) begin
         nonempty[q]   = (count_ff[q] != '0);
         upper_mask[q] = (LIST_W'(q) >= next_start_ff);
      end
   end

   assign {hi_found, hi_idx}  = first_set(nonempty & upper_mask);
   assign {any_found, lo_idx} = first_set(nonempty);
   assign pick = hi_found ? hi_idx : lo_idx;

   assign sel_idx  = LIST_W'(req_ch.queue_select);
   assign sel_ok   = (32'(req_ch.queue_select) < 32'(NUM_LISTS));
   assign push_ok  = !is_take && sel_ok && (count_ff[sel_idx] < CNT_W'(LIST_DEPTH));
   assign take_ok  = is_take && any_found;

   assign slot_sum = (CNT_W+1)'(head_ff[sel_idx]) + (CNT_W+1)'(count_ff[sel_idx]);
   assign slot     = (slot_sum >= (CNT_W+1)'(LIST_DEPTH))
                     ? DEPTH_W'(slot_sum - (CNT_W+1)'(LIST_DEPTH))
                     : DEPTH_W'(slot_sum);
   assign wr_addr  = ADDR_W'(sel_idx) * ADDR_W'(LIST_DEPTH) + ADDR_W'(slot);
   assign rd_addr  = ADDR_W'(pick) * ADDR_W'(LIST_DEPTH) + ADDR_W'(head_ff[pick]);

   assign head_inc = (DEPTH_W+1)'(head_ff[pick]) + 1'b1;
   assign pick_inc = (LIST_W+1)'(pick) + 1'b1;

   always_comb begin
      next_start_in = next_start_ff;
      for (int q = 0; q < NUM_LISTS; q++) begin
         head_in[q]  = head_ff[q];
         count_in[q] = count_ff[q];
         if (accept && push_ok && (LIST_W'(q) == sel_idx)) begin
            count_in[q] = count_ff[q] + 1'b1;
         end
         if (accept && take_ok && (LIST_W'(q) == pick)) begin
            count_in[q] = count_ff[q] - 1'b1;
            head_in[q]  = (head_inc == (DEPTH_W+1)'(LIST_DEPTH)) ? '0 : DEPTH_W'(head_inc);
         end
      end
      if (accept && take_ok) begin
         next_start_in = (pick_inc == (LIST_W+1)'(NUM_LISTS)) ? '0 : LIST_W'(pick_inc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < NUM_LISTS; q++) begin
            head_ff[q]  <= '0;
            count_ff[q] <= '0;
         end
         next_start_ff <= '0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         next_start_ff <= next_start_in;
      end
   end

   always_comb begin
      cmd_out.mem_wr = push_ok;
      cmd_out.mem_rd = take_ok;
      cmd_out.addr   = is_take ? rd_addr : wr_addr;
      cmd_out.data   = req_ch.push_value;
      cmd_out.src    = take_ok ? QSEL_W'(pick) : '0;
      if (is_take) begin
         cmd_out.status = take_ok ? ST_TAKEN : ST_EMPTY;
      end else begin
         cmd_out.status = push_ok ? ST_PUSHED : ST_DROPPED;
      end
   end

   assign cmd_push = accept;

   `RRQI_ASSERT(a_pick_nonempty, !(accept && take_ok) || (count_ff[pick] != '0),
                "take picked an empty queue")
   `RRQI_ASSERT_NEXT(a_empty_keeps_start, accept && is_take && !any_found,
                     $stable(next_start_ff), "empty take moved the round-robin pointer")

endmodule

// ===== sv/rrqi_cmd_fifo.sv =====
`include "round_robin_queue_interleave_core_assert.svh"

module rrqi_cmd_fifo import rrqi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type pop_data
);

   cmd_type               slot_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]  wr_ptr_ff;
   logic [CMD_PTR_W-1:0]  wr_ptr_in;
   logic [CMD_PTR_W-1:0]  rd_ptr_ff;
   logic [CMD_PTR_W-1:0]  rd_ptr_in;
   logic [CMD_CNT_W-1:0]  count_ff;
   logic [CMD_CNT_W-1:0]  count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full     = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `RRQI_ASSERT(a_no_overfill, count_ff <= CMD_CNT_W'(CMD_DEPTH),
                "command queue count beyond depth")
   `RRQI_ASSERT(a_push_has_room, !push || !full, "command pushed into a full queue")

endmodule

// ===== sv/rrqi_back.sv =====
`include "round_robin_queue_interleave_core_assert.svh"

module rrqi_back import rrqi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd_in,
   output logic        cmd_pop,
   rrqi_rsp_if.source  rsp_ch
);

   logic [VALUE_W-1:0] mem [MEM_DEPTH];

   logic               out_valid_ff;
   logic               out_valid_in;
   logic [VALUE_W-1:0] rdata_ff;
   logic [QSEL_W-1:0]  src_ff;
   logic [STAT_W-1:0]  status_ff;
   logic               advance;

   // the output register moves whenever it is empty or being drained
   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign cmd_pop      = cmd_valid && advance;
   assign out_valid_in = advance ? cmd_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         src_ff    <= cmd_in.src;
         status_ff <= cmd_in.status;
         if (cmd_in.mem_wr) begin
            mem[cmd_in.addr] <= cmd_in.data;
         end
         if (cmd_in.mem_rd) begin
            rdata_ff <= mem[cmd_in.addr];
         end
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.out_value    = (status_ff == ST_TAKEN) ? rdata_ff : '0;
   assign rsp_ch.source_queue = src_ff;
   assign rsp_ch.status       = status_ff;

   `RRQI_ASSERT(a_cmd_one_access, !cmd_valid || !(cmd_in.mem_wr && cmd_in.mem_rd),
                "command asks for both a write and a read")
   `RRQI_ASSERT(a_read_iff_taken, !cmd_valid || (cmd_in.mem_rd == (cmd_in.status == ST_TAKEN)),
                "memory read does not match taken status")

endmodule

// ===== sv/round_robin_queue_interleave_core.sv =====
// Channel   Direction  Fields                                   Handshake
// req_ch    in         opcode, queue_select, push_value         valid/ready
// rsp_ch    out        out_value, source_queue, status          valid/ready
//
// One transaction per cycle sustained while rsp_ch is ready; each request yields one response.
// The front updates queue heads/counts and the round-robin pointer at accept; the command
// queue feeds the back, which does the single store access and registers the response.
// The value store has one write and one read port; the back uses at most one per command.
// Reset is synchronous and clears heads, counts, the pointer and the command queue.
// A stalled response holds the back; the front keeps accepting until the 4-entry
// command queue fills.

module round_robin_queue_interleave_core import rrqi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rrqi_req_if.sink    req_ch,
   rrqi_rsp_if.source  rsp_ch
);

   logic    cmd_full;
   logic    cmd_push;
   cmd_type cmd_wr;
   logic    cmd_pop;
   logic    cmd_valid;
   cmd_type cmd_rd;

   rrqi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_out  (cmd_wr)
   );

   rrqi_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .valid     (cmd_valid),
      .pop_data  (cmd_rd)
   );

   rrqi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_in    (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rsp_ch    (rsp_ch)
   );

endmodule
